// ===== sv/srcd_pkg.sv =====
// ----------------------------------------------------------------------------
// srcd_pkg
// shared types and constants of the shift register chain driver
// ----------------------------------------------------------------------------
package srcd_pkg;

  localparam int MAX_CHIPS_DEF = 8;

  localparam int REQ_W = 2;
  localparam int POS_W = 6;
  localparam int VAL_W = 8;
  localparam int CC_W  = 4;

  localparam logic [CC_W-1:0] CHIP_COUNT_RST = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_BIT   = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_SEND  = 2'd3
  } req_type_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic wr_bit;
    logic wr_byte;
    logic clr;
    logic start;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic any_chips;
    logic last_bit;
    logic slot_free;
  } status_t;

endpackage

// ===== sv/srcd_ifs.sv =====
// ----------------------------------------------------------------------------
// srcd interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface srcd_req_if;
  logic                         valid;
  logic                         ready;
  logic [srcd_pkg::REQ_W-1:0]   req_type;
  logic [srcd_pkg::POS_W-1:0]   position;
  logic [srcd_pkg::VAL_W-1:0]   value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink (input valid, req_type, position, value, output ready);
endinterface

interface srcd_rsp_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic last;

  modport source (output valid, serial_bit, last, input ready);
  modport sink (input valid, serial_bit, last, output ready);
endinterface

interface srcd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [srcd_pkg::CC_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/srcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// srcd_ctrl
// request decode and send sequencing
// ----------------------------------------------------------------------------
module srcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srcd_pkg::req_type_t req_type,
  input  srcd_pkg::status_t   status,
  output srcd_pkg::cmd_t      cmd
);

  srcd_pkg::state_t state;
  srcd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      srcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_type)
            srcd_pkg::REQ_BIT:   cmd.wr_bit  = 1'b1;
            srcd_pkg::REQ_BYTE:  cmd.wr_byte = 1'b1;
            srcd_pkg::REQ_CLEAR: cmd.clr     = 1'b1;
            srcd_pkg::REQ_SEND: begin
              if (status.any_chips) begin
                cmd.start  = 1'b1;
                state_next = srcd_pkg::ST_SEND;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      srcd_pkg::ST_SEND: begin
        if (status.slot_free) begin
          cmd.shift = 1'b1;
          if (status.last_bit) begin
            state_next = srcd_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = srcd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/srcd_dp.sv =====
// ----------------------------------------------------------------------------
// srcd_dp
// shadow byte store, chip count register, bit counter and output register
// ----------------------------------------------------------------------------
module srcd_dp #(
  parameter int MAX_CHIPS = srcd_pkg::MAX_CHIPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [srcd_pkg::CC_W-1:0]   cfg_data,
  input  logic [srcd_pkg::POS_W-1:0]  position,
  input  logic [srcd_pkg::VAL_W-1:0]  value,
  input  srcd_pkg::cmd_t              cmd,
  output srcd_pkg::status_t           status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        serial_bit,
  output logic                        last
);

  localparam int BW   = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int CW   = $clog2(MAX_CHIPS + 1);
  localparam int CNTW = BW + 3;

  logic [srcd_pkg::CC_W-1:0]  chip_count;
  logic [CW-1:0]              n_chips;
  logic [CW-1:0]              n_m1;
  logic [srcd_pkg::POS_W-1:0] n_ext;
  logic [7:0]                 shadow [MAX_CHIPS];
  logic [CNTW-1:0]            cnt;
  logic [7:0]                 cur_byte;
  logic                       cur_bit;
  logic                       bit_ok;
  logic                       byte_ok;
  logic [BW-1:0]              bit_idx;
  logic [BW-1:0]              byte_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count <= srcd_pkg::CHIP_COUNT_RST;
    end else if (cfg_we) begin
      chip_count <= cfg_data;
    end
  end

  always_comb begin
    if (chip_count > srcd_pkg::CC_W'(MAX_CHIPS)) begin
      n_chips = CW'(MAX_CHIPS);
    end else begin
      n_chips = CW'(chip_count);
    end
    n_m1     = n_chips - CW'(1);
    n_ext    = srcd_pkg::POS_W'(n_chips);
    bit_ok   = srcd_pkg::POS_W'(position[5:3]) < n_ext;
    byte_ok  = position < n_ext;
    bit_idx  = position[3 +: BW];
    byte_idx = position[BW-1:0];
    cur_byte = shadow[cnt[CNTW-1:3]];
    cur_bit  = cur_byte[3'(3'd7 - cnt[2:0])];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < MAX_CHIPS; b++) begin
        shadow[b] <= 8'd0;
      end
    end else if (cmd.wr_bit && bit_ok) begin
      shadow[bit_idx][position[2:0]] <= value[0];
    end else if (cmd.wr_byte && byte_ok) begin
      shadow[byte_idx] <= value;
    end else if (cmd.clr) begin
      for (int b = 0; b < MAX_CHIPS; b++) begin
        if (CW'(b) < n_chips) begin
          shadow[b] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.shift) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.shift) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      serial_bit <= cur_bit;
      last       <= status.last_bit;
    end
  end

  always_comb begin
    status.any_chips = n_chips != '0;
    status.last_bit  = (cnt[CNTW-1:3] == BW'(n_m1)) && (cnt[2:0] == 3'd7);
    status.slot_free = !out_valid || out_ready;
  end

endmodule

// ===== sv/shift_register_chain_driver_top.sv =====
// ----------------------------------------------------------------------------
// shift_register_chain_driver_top
// shadow store and serializer for a chain of serial-in parallel-out chips
// ----------------------------------------------------------------------------
// Bit writes, byte writes and clears update the store when accepted. A send
// beat is accepted, then the store goes out one bit per cycle while the result
// side takes them, byte 0 first and MSB first, 8 result beats per chip in use
// (chip_count, capped at MAX_CHIPS) with last set on the final one; a single
// bit counter walks the store. No request is taken during a send. A send with
// no chips in use gives no beats. The user must write chip_count through cfg
// only while the block is idle; the block itself does not enforce it.
module shift_register_chain_driver_top #(
  parameter int MAX_CHIPS = srcd_pkg::MAX_CHIPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srcd_cfg_if.sink   cfg,
  srcd_req_if.sink   req,
  srcd_rsp_if.source rsp
);

  srcd_pkg::cmd_t    cmd;
  srcd_pkg::status_t status;

  assign cfg.ready = 1'b1;

  srcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .req_type (srcd_pkg::req_type_t'(req.req_type)),
    .status   (status),
    .cmd      (cmd)
  );

  srcd_dp #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.data),
    .position   (req.position),
    .value      (req.value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .serial_bit (rsp.serial_bit),
    .last       (rsp.last)
  );

endmodule
